[src/assert_macros.svh]
// Assertion macros shared by the stack RTL.
// Every macro takes a label, a clock and an active-low reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The expression holds on every clock edge out of reset.
`define ASSERT_ALWAYS(label, clk, rst_n, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("assertion failed: invariant");

// The consequent holds in the same cycle as the antecedent.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");

// The consequent holds in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`endif

[src/bsmp_pkg.sv]
// ----------------------------------------------------------------------------
// bsmp_pkg: shared types and constants of the bounded stack
// Field widths, reset values, outcome codes, controller states and the
// command bundle passed from the controller to the datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package bsmp_pkg;

    // Default structural sizes.
    localparam int DEPTH_DEF    = 1024;
    localparam int MAX_POPS_DEF = 64;

    // Fixed field widths.
    localparam int VAL_W   = 32;
    localparam int CAP_W   = 11;
    localparam int COUNT_W = 7;

    // Capacity after reset.
    localparam logic [CAP_W-1:0] CAP_RESET = 11'd1024;

    // Result outcome codes.
    typedef enum logic [1:0] {
        OUT_STORED = 2'd0,
        OUT_REJECT = 2'd1,
        OUT_POPPED = 2'd2,
        OUT_EMPTY  = 2'd3
    } t_outcome;

    // Controller states.
    typedef enum logic {
        ST_IDLE = 1'b0,
        ST_POP  = 1'b1
    } t_state;

    // Per-cycle command from the controller.
    typedef struct packed {
        logic push;
        logic pop;
        logic last;
    } t_cmd;

endpackage

`default_nettype wire

[src/bsmp_ctrl.sv]
// ----------------------------------------------------------------------------
// bsmp_ctrl: stack operation sequencer
// Accepts items, saturates the pop count and issues one push or pop
// command per cycle to the datapath, holding busy while a pop burst runs.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module bsmp_ctrl
    import bsmp_pkg::*;
#(
    parameter int MAX_POPS = MAX_POPS_DEF
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               start,
    output logic                    busy,
    input  wire logic               i_operation,
    input  wire logic [COUNT_W-1:0] i_pop_count,
    output t_cmd                    o_cmd
);

    localparam logic [COUNT_W-1:0] MaxPops = COUNT_W'(MAX_POPS);

    t_state             r_state;
    t_state             n_state;
    logic [COUNT_W-1:0] r_left;
    logic [COUNT_W-1:0] n_left;
    logic [COUNT_W-1:0] cnt_sat;
    logic               accept;

    assign busy    = (r_state == ST_POP);
    assign accept  = start && !busy;
    assign cnt_sat = (i_pop_count > MaxPops) ? MaxPops : i_pop_count;

    // State and remaining-pop registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_left  <= '0;
        end else begin
            r_state <= n_state;
            r_left  <= n_left;
        end
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (accept && i_operation && (cnt_sat > COUNT_W'(1))) begin
                    n_state = ST_POP;
                end
            end
            ST_POP: begin
                if (r_left == COUNT_W'(1)) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // Commands and the burst counter.
    always_comb begin
        o_cmd  = '0;
        n_left = r_left;
        case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    if (!i_operation) begin
                        o_cmd.push = 1'b1;
                        o_cmd.last = 1'b1;
                    end else if (cnt_sat != '0) begin
                        o_cmd.pop  = 1'b1;
                        o_cmd.last = (cnt_sat == COUNT_W'(1));
                        n_left     = cnt_sat - COUNT_W'(1);
                    end
                end
            end
            ST_POP: begin
                o_cmd.pop  = 1'b1;
                o_cmd.last = (r_left == COUNT_W'(1));
                n_left     = r_left - COUNT_W'(1);
            end
            default: n_left = '0;
        endcase
    end

    // A push and a pop never go out together.
    `ASSERT_ALWAYS(a_one_cmd, i_clk, i_rst_n, !(o_cmd.push && o_cmd.pop))
    // A running burst always has pops left to issue.
    `ASSERT_IMPL(a_left_live, i_clk, i_rst_n, r_state == ST_POP, r_left != '0)
    // The last pop of a burst frees the controller.
    `ASSERT_NEXT(a_burst_end, i_clk, i_rst_n, (r_state == ST_POP) && o_cmd.last,
                 r_state == ST_IDLE)

endmodule

`default_nettype wire

[src/bsmp_dpath.sv]
// ----------------------------------------------------------------------------
// bsmp_dpath: stack storage, entry count and result registers
// Executes push and pop commands against the stack memory and registers
// one result beat per command.
// ----------------------------------------------------------------------------
`default_nettype none

module bsmp_dpath
    import bsmp_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF
) (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire t_cmd                    i_cmd,
    input  wire logic signed [VAL_W-1:0] i_push_value,
    input  wire logic                    i_cfg_we,
    input  wire logic [CAP_W-1:0]        i_cfg_wdata,
    output logic                         o_result_valid,
    output logic [1:0]                   o_outcome,
    output logic signed [VAL_W-1:0]      o_pop_value,
    output logic                         o_is_empty,
    output logic                         o_is_full,
    output logic                         o_last
);

    localparam int AW    = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int CMP_W = (CNT_W > CAP_W) ? CNT_W : CAP_W;

    logic [VAL_W-1:0] mem [DEPTH];

    logic [CAP_W-1:0] r_cap;
    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] n_count;
    logic             r_valid;
    t_outcome         r_outcome;
    t_outcome         n_outcome;
    logic             r_empty;
    logic             r_full;
    logic             r_last;
    logic [VAL_W-1:0] r_rdata;
    logic             full_now;
    logic             wr_en;
    logic             rd_en;
    logic [AW-1:0]    rd_addr;

    // Full when the count reaches the capacity, or the memory depth.
    function automatic logic full_f(input logic [CNT_W-1:0] c,
                                    input logic [CAP_W-1:0] cap);
        full_f = (CMP_W'(c) >= CMP_W'(cap)) || (c == CNT_W'(DEPTH));
    endfunction

    assign full_now = full_f(r_count, r_cap);
    assign rd_addr  = AW'(r_count - CNT_W'(1));

    // Command decode: new count, outcome and memory enables.
    always_comb begin
        n_count   = r_count;
        n_outcome = OUT_STORED;
        wr_en     = 1'b0;
        rd_en     = 1'b0;
        if (i_cmd.push) begin
            if (full_now) begin
                n_outcome = OUT_REJECT;
            end else begin
                n_outcome = OUT_STORED;
                wr_en     = 1'b1;
                n_count   = r_count + CNT_W'(1);
            end
        end else if (i_cmd.pop) begin
            if (r_count == '0) begin
                n_outcome = OUT_EMPTY;
            end else begin
                n_outcome = OUT_POPPED;
                rd_en     = 1'b1;
                n_count   = r_count - CNT_W'(1);
            end
        end
    end

    // Capacity register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap <= CAP_RESET;
        end else if (i_cfg_we) begin
            r_cap <= i_cfg_wdata;
        end
    end

    // Stack memory with a registered read port.
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[AW'(r_count)] <= i_push_value;
        end
        if (rd_en) begin
            r_rdata <= mem[rd_addr];
        end
    end

    // Entry count and result strobe.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_valid <= 1'b0;
        end else begin
            r_count <= n_count;
            r_valid <= i_cmd.push || i_cmd.pop;
        end
    end

    // Result fields, with flags taken after the action.
    always_ff @(posedge i_clk) begin
        if (i_cmd.push || i_cmd.pop) begin
            r_outcome <= n_outcome;
            r_empty   <= (n_count == '0);
            r_full    <= full_f(n_count, r_cap);
            r_last    <= i_cmd.last;
        end
    end

    assign o_result_valid = r_valid;
    assign o_outcome      = r_outcome;
    assign o_pop_value    = (r_outcome == OUT_POPPED) ? r_rdata : '0;
    assign o_is_empty     = r_empty;
    assign o_is_full      = r_full;
    assign o_last         = r_last;

endmodule

`default_nettype wire

[src/bounded_stack_multi_pop.sv]
// ----------------------------------------------------------------------------
// bounded_stack_multi_pop: bounded LIFO stack with counted pops
// Items enter on start while busy is low. A push (operation 0) stores
// push_value unless the stack is full and gives one result beat. A pop
// (operation 1) gives pop_count beats, saturated to MAX_POPS, each the
// removed top value or an empty mark; the final beat has o_last set, and a
// count of zero gives no beat.
// Every result beat is on the output ports for exactly one cycle, marked by
// o_result_valid, in the cycle after the command that makes it. The receiver
// cannot stall the block and must take each beat when it appears.
// After a push, the next item can follow at once. A pop burst issues its pops
// back to back, with busy high from its second pop through its last, since
// the single read port of the stack memory serves one pop per cycle.
// The user must write the capacity register (i_cfg_we, i_cfg_wdata) only while
// idle; the block itself does not enforce it. Values above DEPTH act as DEPTH.
// Reset (synchronous, active low) empties the stack, sets the capacity to
// 1024 and needs no clearing pass: stale memory words are never read.
// ----------------------------------------------------------------------------
`default_nettype none

module bounded_stack_multi_pop
    import bsmp_pkg::*;
#(
    parameter int DEPTH    = DEPTH_DEF,
    parameter int MAX_POPS = MAX_POPS_DEF
) (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire logic                    start,
    output logic                         busy,
    input  wire logic                    i_operation,
    input  wire logic signed [VAL_W-1:0] i_push_value,
    input  wire logic [COUNT_W-1:0]      i_pop_count,
    input  wire logic                    i_cfg_we,
    input  wire logic [CAP_W-1:0]        i_cfg_wdata,
    output logic                         o_result_valid,
    output logic [1:0]                   o_outcome,
    output logic signed [VAL_W-1:0]      o_pop_value,
    output logic                         o_is_empty,
    output logic                         o_is_full,
    output logic                         o_last
);

    t_cmd cmd;

    // Sequencer.
    bsmp_ctrl #(
        .MAX_POPS (MAX_POPS)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_operation (i_operation),
        .i_pop_count (i_pop_count),
        .o_cmd       (cmd)
    );

    // Storage and results.
    bsmp_dpath #(
        .DEPTH (DEPTH)
    ) u_dpath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .i_push_value   (i_push_value),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_wdata    (i_cfg_wdata),
        .o_result_valid (o_result_valid),
        .o_outcome      (o_outcome),
        .o_pop_value    (o_pop_value),
        .o_is_empty     (o_is_empty),
        .o_is_full      (o_is_full),
        .o_last         (o_last)
    );

endmodule

`default_nettype wire

[dv/tb_top.sv]
// ----------------------------------------------------------------------------
// tb_top: self-checking testbench for bounded_stack_multi_pop
// Runs a short directed sequence through the stack corner cases. These are
// pops on empty, saturated pop counts, a capacity of zero, a capacity above
// the depth, and a capacity lowered below the fill level. Then it runs random
// phases of push bursts and counted pops under small capacities. A mirror of
// the stack predicts every result beat, and the monitor checks each beat
// field by field against the oldest prediction.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_top;
    import bsmp_pkg::*;

    localparam logic OP_PUSH      = 1'b0;
    localparam logic OP_POP       = 1'b1;
    localparam int   RAND_ITEMS   = 145;
    localparam int   DRAIN_SETTLE = 4;
    localparam int   MAX_GAP      = 16;

    // Kinds of entries in the stimulus backlog.
    typedef enum logic [1:0] {
        ACT_ITEM,
        ACT_CFG,
        ACT_DRAIN
    } t_act;

    typedef struct {
        t_act                    act;
        logic                    op;
        logic signed [VAL_W-1:0] value;
        logic [COUNT_W-1:0]      cnt;
        logic [CAP_W-1:0]        cap;
        int                      gap;
    } t_stim;

    typedef struct {
        t_outcome                outcome;
        logic signed [VAL_W-1:0] value;
        logic                    empty;
        logic                    full;
        logic                    last;
    } t_beat;

    logic                    i_clk = 1'b0;
    logic                    i_rst_n = 1'b0;
    logic                    start = 1'b0;
    logic                    busy;
    logic                    i_operation = 1'b0;
    logic signed [VAL_W-1:0] i_push_value = '0;
    logic [COUNT_W-1:0]      i_pop_count = '0;
    logic                    i_cfg_we = 1'b0;
    logic [CAP_W-1:0]        i_cfg_wdata = '0;
    logic                    o_result_valid;
    logic [1:0]              o_outcome;
    logic signed [VAL_W-1:0] o_pop_value;
    logic                    o_is_empty;
    logic                    o_is_full;
    logic                    o_last;

    bounded_stack_multi_pop dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_operation    (i_operation),
        .i_push_value   (i_push_value),
        .i_pop_count    (i_pop_count),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_wdata    (i_cfg_wdata),
        .o_result_valid (o_result_valid),
        .o_outcome      (o_outcome),
        .o_pop_value    (o_pop_value),
        .o_is_empty     (o_is_empty),
        .o_is_full      (o_is_full),
        .o_last         (o_last)
    );

    // Stimulus backlog and the beats the stack is still due to produce.
    t_stim cmd_backlog[$];
    t_beat due_beats[$];
    int    err_cnt = 0;
    bit    calm = 1'b0;
    bit    feed_done = 1'b0;
    logic  item_taken = 1'b0;

    // Mirror of the stack contents, fill level and capacity register.
    logic signed [VAL_W-1:0] mirror_mem [DEPTH_DEF];
    int                      mirror_cnt = 0;
    logic [CAP_W-1:0]        mirror_cap = CAP_RESET;

    // Driver state.
    int idle_left = 0;
    int settle_left = 0;
    bit draining = 1'b0;
    bit gap_spent = 1'b0;

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // Apply one accepted item to the mirror and queue the beats it causes.
    task automatic stack_step(input logic op, input logic signed [VAL_W-1:0] val,
                              input logic [COUNT_W-1:0] cnt);
        int    lim;
        int    n;
        int    i;
        t_beat b;
        lim = (mirror_cap > DEPTH_DEF) ? DEPTH_DEF : int'(mirror_cap);
        if (op == OP_PUSH) begin
            if (mirror_cnt >= lim) begin
                b.outcome = OUT_REJECT;
            end else begin
                mirror_mem[mirror_cnt] = val;
                mirror_cnt++;
                b.outcome = OUT_STORED;
            end
            b.value = '0;
            b.empty = (mirror_cnt == 0);
            b.full  = (mirror_cnt >= lim);
            b.last  = 1'b1;
            due_beats.push_back(b);
        end else begin
            n = (cnt > MAX_POPS_DEF) ? MAX_POPS_DEF : int'(cnt);
            for (i = 0; i < n; i++) begin
                if (mirror_cnt == 0) begin
                    b.outcome = OUT_EMPTY;
                    b.value   = '0;
                end else begin
                    mirror_cnt--;
                    b.outcome = OUT_POPPED;
                    b.value   = mirror_mem[mirror_cnt % DEPTH_DEF];
                end
                b.empty = (mirror_cnt == 0);
                b.full  = (mirror_cnt >= lim);
                b.last  = (i == n - 1);
                due_beats.push_back(b);
            end
        end
    endtask

    task automatic flag_field(input string name, input logic [VAL_W-1:0] want,
                              input logic [VAL_W-1:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
            err_cnt++;
        end
    endtask

    // Monitor: check the result beat of this cycle, track capacity writes and
    // predict the beats of an item accepted at this edge.
    always @(posedge i_clk) begin
        t_beat want;
        logic  taken;
        if (!i_rst_n) begin
            item_taken <= 1'b0;
        end else begin
            if (o_result_valid !== 1'b0) begin
                if (due_beats.size() == 0) begin
                    $display("%0t: result beat with none expected, expected none, actual %0h",
                             $time, o_outcome);
                    err_cnt++;
                end else begin
                    want = due_beats.pop_front();
                    flag_field("outcome", VAL_W'(want.outcome), VAL_W'(o_outcome));
                    flag_field("pop_value", want.value, o_pop_value);
                    flag_field("is_empty", VAL_W'(want.empty), VAL_W'(o_is_empty));
                    flag_field("is_full", VAL_W'(want.full), VAL_W'(o_is_full));
                    flag_field("last", VAL_W'(want.last), VAL_W'(o_last));
                end
            end
            if (i_cfg_we) begin
                mirror_cap = i_cfg_wdata;
            end
            taken = (start === 1'b1) && (busy === 1'b0);
            if (taken) begin
                stack_step(i_operation, i_push_value, i_pop_count);
            end
            item_taken <= taken;
        end
    end

    // Driver: hold an item until it is taken, then idle for the drawn gap
    // and present the next backlog entry.
    always @(negedge i_clk) begin
        t_stim ent;
        logic  nxt_start;
        logic  nxt_we;
        if (i_rst_n && !(start && !item_taken)) begin
            nxt_start = 1'b0;
            nxt_we    = 1'b0;
            if (idle_left > 0) begin
                idle_left--;
            end else if (draining) begin
                if (due_beats.size() == 0 && busy === 1'b0) begin
                    if (settle_left > 0) begin
                        settle_left--;
                    end else begin
                        draining = 1'b0;
                    end
                end
            end else if (cmd_backlog.size() == 0) begin
                feed_done = 1'b1;
            end else if (!gap_spent && cmd_backlog[0].gap > 0) begin
                idle_left = cmd_backlog[0].gap - 1;
                gap_spent = 1'b1;
            end else begin
                ent = cmd_backlog.pop_front();
                gap_spent = 1'b0;
                case (ent.act)
                    ACT_ITEM: begin
                        nxt_start = 1'b1;
                        i_operation  <= ent.op;
                        i_push_value <= ent.value;
                        i_pop_count  <= ent.cnt;
                    end
                    ACT_CFG: begin
                        nxt_we = 1'b1;
                        i_cfg_wdata <= ent.cap;
                    end
                    default: begin
                        draining = 1'b1;
                        settle_left = DRAIN_SETTLE;
                    end
                endcase
            end
            start    <= nxt_start;
            i_cfg_we <= nxt_we;
        end
    end

    function automatic int draw_gap();
        return calm ? 0 : int'($urandom_range(0, MAX_GAP));
    endfunction

    task automatic queue_item(input logic op, input logic [VAL_W-1:0] val,
                              input logic [COUNT_W-1:0] cnt);
        t_stim s;
        s.act   = ACT_ITEM;
        s.op    = op;
        s.value = val;
        s.cnt   = cnt;
        s.cap   = '0;
        s.gap   = draw_gap();
        cmd_backlog.push_back(s);
    endtask

    // A capacity write always waits for the stack to go quiet first.
    task automatic queue_cfg(input logic [CAP_W-1:0] cap);
        t_stim s;
        s.op    = OP_PUSH;
        s.value = '0;
        s.cnt   = '0;
        s.cap   = cap;
        s.gap   = draw_gap();
        s.act   = ACT_DRAIN;
        cmd_backlog.push_back(s);
        s.act   = ACT_CFG;
        cmd_backlog.push_back(s);
    endtask

    // Stimulus: directed corner cases, then random phases.
    initial begin
        int items;
        int phase_end;
        int plan_cap;
        int k;

        // Pops on an empty stack, including a count of zero.
        queue_item(OP_POP, 32'h0, 7'd0);
        queue_item(OP_POP, 32'hFFFF_FFFF, 7'd1);
        // Extreme push values.
        queue_item(OP_PUSH, 32'h7FFF_FFFF, 7'd127);
        queue_item(OP_PUSH, 32'h8000_0000, 7'd0);
        queue_item(OP_PUSH, 32'h0000_0000, 7'd64);
        queue_item(OP_PUSH, 32'hFFFF_FFFF, 7'd1);
        queue_item(OP_PUSH, 32'h5555_AAAA, 7'd85);
        queue_item(OP_POP, 32'h0, 7'd2);
        // Count above the maximum saturates and runs past empty.
        queue_item(OP_POP, 32'h1234_5678, 7'd127);
        queue_item(OP_POP, 32'h0, 7'd64);
        // Capacity zero: always full, pushes rejected.
        queue_cfg(11'd0);
        queue_item(OP_PUSH, 32'hDEAD_BEEF, 7'd0);
        queue_item(OP_POP, 32'h0, 7'd2);
        // Capacity above the depth acts as the depth.
        queue_cfg(11'd2047);
        queue_item(OP_PUSH, 32'h0000_0001, 7'd0);
        queue_item(OP_PUSH, 32'h8000_0001, 7'd0);
        queue_item(OP_PUSH, 32'h7FFF_FFFE, 7'd0);
        // Capacity lowered below the fill level.
        queue_cfg(11'd1);
        queue_item(OP_PUSH, 32'hCAFE_F00D, 7'd0);
        queue_item(OP_POP, 32'h0, 7'd1);
        queue_item(OP_POP, 32'h0, 7'd1);
        queue_item(OP_POP, 32'h0, 7'd1);
        queue_item(OP_PUSH, 32'hA5A5_5A5A, 7'd0);
        queue_item(OP_PUSH, 32'h5A5A_A5A5, 7'd0);
        queue_cfg(CAP_RESET);
        queue_item(OP_POP, 32'h0, 7'd1);

        // Random phases: each sets a fresh capacity, mostly small so the
        // stack hits full and empty often, and picks whether to idle.
        items = 0;
        phase_end = 0;
        plan_cap = 1;
        while (items < RAND_ITEMS) begin
            if (items >= phase_end) begin
                plan_cap = ($urandom_range(0, 3) == 0) ? int'($urandom_range(13, 48))
                                                       : int'($urandom_range(1, 12));
                calm = ($urandom_range(0, 2) == 0);
                queue_cfg(plan_cap[CAP_W-1:0]);
                phase_end = items + int'($urandom_range(20, 35));
            end
            if ($urandom_range(0, 4) == 0) begin
                // Stray item with any field values.
                queue_item(1'($urandom_range(0, 1)), $urandom, 7'($urandom_range(0, 127)));
                items++;
            end else begin
                // Burst of pushes followed by a pop of about the same size.
                k = int'($urandom_range(1, (plan_cap + 2 > 16) ? 16 : plan_cap + 2));
                repeat (k) begin
                    queue_item(OP_PUSH, $urandom, 7'($urandom_range(0, 127)));
                end
                queue_item(OP_POP, $urandom, 7'($urandom_range(0, k + 2)));
                items += k + 1;
            end
        end

        // Release reset at a falling clock edge.
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        wait (feed_done);
        while (due_beats.size() != 0) begin
            @(negedge i_clk);
        end
        repeat (8) @(negedge i_clk);
        if (err_cnt == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

    // Watchdog far beyond the slowest correct run.
    initial begin
        #2000000;
        $display("Test completed with failures");
        $finish;
    end

endmodule

`default_nettype wire
